FILE: rtl/position_dependent_rate_defines.svh
// ----------------------------------------------------------------------------
// position_dependent_rate assertion macros
// Shared property shapes for the checker; clk and rst come from the user.
// ----------------------------------------------------------------------------
`ifndef POSITION_DEPENDENT_RATE_DEFINES_SVH
`define POSITION_DEPENDENT_RATE_DEFINES_SVH

// Same-cycle implication, reset masked.
`define PDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define PDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pdr_pkg.sv
// ----------------------------------------------------------------------------
// pdr_pkg
// Types, codes, constants and the exp ROM for position_dependent_rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);

  // Pipeline depth from input beat to result strobe.
  localparam int PDR_LAT = 7;

  localparam logic [63:0]        LN2_Q30   = 64'd744261118;
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  // 32.0 in Q.32 natural units
  localparam logic signed [48:0] EXP_LIMIT = 49'sd137438953472;
  localparam logic [32:0]        SAT_MAG   = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_CONST = 2'd1,
    KIND_EXP   = 2'd2,
    KIND_WALL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_CAP   = 2'd1,
    CLAMP_FLOOR = 2'd2
  } clamp_t;

  typedef enum logic [2:0] {
    REG_RATE_KIND     = 3'd0,
    REG_AMPLITUDE     = 3'd1,
    REG_DECAY         = 3'd2,
    REG_WALL_DISTANCE = 3'd3,
    REG_RATE_CAP      = 3'd4
  } reg_idx_t;

  // front half -> back half
  typedef struct packed {
    logic              valid;
    logic              sat;       // exponent above +32
    logic              zero;      // exponent below -32
    logic              wall_hit;
    logic signed [6:0] n;         // integer part of base-2 exponent
    logic [31:0]       rom_val;   // 2^frac, Q2.30
  } front_t;

  // back half -> output stage
  typedef struct packed {
    logic        valid;
    logic        wall_hit;
    logic [32:0] mag;             // saturated at 2^32
  } back_t;

  typedef logic [31:0] rom_t [EXP_TABLE_DEPTH];

  // 2^(i/depth) in Q2.30 by a truncated Taylor series of exp(i*ln2/depth)
  function automatic logic [31:0] exp_rom_entry(int unsigned i);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    sum  = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

  function automatic rom_t exp_rom_init();
    rom_t r;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      r[i] = exp_rom_entry(i);
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = exp_rom_init();

endpackage

FILE: rtl/position_dependent_rate.sv
// ----------------------------------------------------------------------------
// position_dependent_rate
// Transition rate from a signed position: none, constant, exponential or wall.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse start with x_position (signed Q12.12 nm). busy is always low,
//   so a beat is taken on every cycle that start is high.
//   Output: done strobes for one cycle with rate (Q24.8 per s) and
//   clamp_kind (none, capped at the rate cap, floored at zero). The receiver
//   cannot stall; each result is there for exactly that cycle.
//   Throughput is one beat per cycle. The pipeline depth is set by the three
//   multipliers (decay * position, exponent * log2 e, amplitude * ROM), the
//   ROM read and the rounding shifter, each in a stage of its own.
//   Config: cfg_write, cfg_index, cfg_data write one register per cycle
//   (0 kind, 1 amplitude, 2 decay, 3 wall distance, 4 rate cap); other
//   indexes are dropped. The user must make writes while no beat is in flight,
//   as the later stages read the live registers; the block does not enforce it.
//   Reset (rst, synchronous) empties the pipeline, clears the other config
//   registers and sets the rate cap to all ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module position_dependent_rate import pdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] x_position,
  output logic               done,
  output logic [31:0]        rate,
  output logic [1:0]         clamp_kind,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers
  kind_t              rate_kind;
  logic signed [31:0] amplitude;
  logic signed [23:0] decay;
  logic [23:0]        wall_distance;
  logic [31:0]        rate_cap;

  front_t front;
  back_t  back;

  logic [31:0] amag;
  logic [32:0] mag;
  logic [31:0] rate_next;
  clamp_t      clamp_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_kind     <= KIND_NONE;
      amplitude     <= '0;
      decay         <= '0;
      wall_distance <= '0;
      rate_cap      <= '1;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_RATE_KIND:     rate_kind     <= kind_t'(cfg_data[1:0]);
        REG_AMPLITUDE:     amplitude     <= cfg_data;
        REG_DECAY:         decay         <= cfg_data[23:0];
        REG_WALL_DISTANCE: wall_distance <= cfg_data[23:0];
        REG_RATE_CAP:      rate_cap      <= cfg_data;
        default: ;
      endcase
    end
  end

  // |amplitude|; -2^31 maps to 2^31 in 32 unsigned bits
  assign amag = amplitude[31] ? 32'(-amplitude) : amplitude;

  // stages 1..3
  pdr_exp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .x_position    (x_position),
    .decay         (decay),
    .wall_distance (wall_distance),
    .front         (front)
  );

  // stages 4..6
  pdr_exp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .front (front),
    .amag  (amag),
    .back  (back)
  );

  // stage 7: pick magnitude by kind, then cap / floor
  always_comb begin
    case (rate_kind)
      KIND_CONST: mag = {1'b0, amag};
      KIND_EXP:   mag = back.mag;
      KIND_WALL:  mag = back.wall_hit ? {1'b0, amag} : 33'd0;
      default:    mag = '0;
    endcase
    // zero amplitude gives zero even where the exponent saturates
    if (amplitude == '0) begin
      mag = '0;
    end

    if (mag == '0) begin
      rate_next  = '0;
      clamp_next = CLAMP_NONE;
    end else if (amplitude[31]) begin
      rate_next  = '0;
      clamp_next = CLAMP_FLOOR;
    end else if (mag > {1'b0, rate_cap}) begin
      rate_next  = rate_cap;
      clamp_next = CLAMP_CAP;
    end else begin
      rate_next  = mag[31:0];
      clamp_next = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= back.valid;
    end
  end

  always_ff @(posedge clk) begin
    rate       <= rate_next;
    clamp_kind <= clamp_next;
  end

endmodule

FILE: rtl/pdr_exp_front.sv
// ----------------------------------------------------------------------------
// pdr_exp_front
// Exponent product, base-2 conversion and ROM lookup (three stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_exp_front import pdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [23:0] x_position,
  input  logic signed [23:0] decay,
  input  logic [23:0]        wall_distance,
  output front_t             front
);

  // stage 1
  logic               v1;
  logic signed [48:0] e1;
  logic               wall1;
  // stage 2
  logic               v2;
  logic signed [62:0] t2;
  logic               sat2, zero2, wall2;
  // stage 3
  logic               v3;
  logic signed [6:0]  n3;
  logic [31:0]        rom3;
  logic               sat3, zero3, wall3;

  logic signed [47:0]        prod;
  logic [23:0]               xabs;
  logic signed [30:0]        e24;
  logic signed [62:0]        t_next;
  logic [23:0]               frac;
  logic [24+IDX_W:0]         frac_scaled;
  logic [IDX_W-1:0]          idx;

  assign prod   = decay * x_position;
  assign xabs   = x_position[23] ? 24'(-x_position) : x_position;
  assign e24    = e1[38:8];               // floor(e / 2^8), valid inside the limit
  assign t_next = e24 * LOG2E_Q30;
  assign frac   = t2[53:30];
  assign frac_scaled = (25 + IDX_W)'(frac) * (25 + IDX_W)'(EXP_TABLE_DEPTH);
  assign idx    = frac_scaled[24 +: IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    e1    <= -$signed({prod[47], prod});
    wall1 <= (xabs <= wall_distance);

    t2    <= t_next;
    sat2  <= (e1 > EXP_LIMIT);
    zero2 <= (e1 < -EXP_LIMIT);
    wall2 <= wall1;

    n3    <= t2[60:54];                     // floor(t / 2^24) of t = floor(prod / 2^30)
    rom3  <= EXP_ROM[idx];
    sat3  <= sat2;
    zero3 <= zero2;
    wall3 <= wall2;
  end

  assign front.valid    = v3;
  assign front.sat      = sat3;
  assign front.zero     = zero3;
  assign front.wall_hit = wall3;
  assign front.n        = n3;
  assign front.rom_val  = rom3;

endmodule

FILE: rtl/pdr_exp_back.sv
// ----------------------------------------------------------------------------
// pdr_exp_back
// Amplitude scaling and the 2^(n-30) shift with rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_exp_back import pdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  front_t      front,
  input  logic [31:0] amag,
  output back_t       back
);

  // stage 4
  logic              v4;
  logic [63:0]       p4;
  logic signed [7:0] s4;
  logic              sat4, zero4, wall4;
  // stage 5
  logic              v5;
  logic              left5, big5;
  logic [32:0]       lmag5;
  logic [63:0]       rsum5;
  logic [5:0]        rsh5;
  logic              sat5, zero5, wall5;
  // stage 6
  logic              v6;
  logic [32:0]       mag6;
  logic              wall6;

  logic [4:0]  lsh;
  logic [32:0] thr;
  logic [63:0] lshift;
  logic [7:0]  rneg;
  logic [63:0] rsum_next;
  logic [63:0] rval;
  logic [32:0] mag_next;

  // left shift: s in 0..16
  assign lsh    = s4[4:0];
  assign thr    = SAT_MAG >> lsh;
  assign lshift = p4 << lsh;
  // right shift: r = -s, rounding half up
  assign rneg      = 8'(-s4);
  assign rsum_next = p4 + (64'd1 << (rneg[5:0] - 6'd1));
  assign rval      = rsum5 >> rsh5;

  always_comb begin
    if (sat5) begin
      mag_next = SAT_MAG;
    end else if (zero5) begin
      mag_next = '0;
    end else if (left5) begin
      mag_next = lmag5;
    end else if (big5) begin
      mag_next = '0;
    end else if (rval > 64'(SAT_MAG)) begin
      mag_next = SAT_MAG;
    end else begin
      mag_next = rval[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v4 <= front.valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    p4    <= 64'(amag) * 64'(front.rom_val);
    s4    <= 8'(front.n) - 8'sd30;
    sat4  <= front.sat;
    zero4 <= front.zero;
    wall4 <= front.wall_hit;

    left5 <= !s4[7];
    lmag5 <= (p4 > 64'(thr)) ? SAT_MAG : lshift[32:0];
    big5  <= (rneg >= 8'd63);
    rsum5 <= rsum_next;
    rsh5  <= rneg[5:0];
    sat5  <= sat4;
    zero5 <= zero4;
    wall5 <= wall4;

    mag6  <= mag_next;
    wall6 <= wall5;
  end

  assign back.valid    = v6;
  assign back.wall_hit = wall6;
  assign back.mag      = mag6;

endmodule

FILE: rtl/pdr_checker.sv
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level timing and result checks, bound to position_dependent_rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "position_dependent_rate_defines.svh"

module pdr_checker import pdr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] rate,
  input logic [1:0]  clamp_kind
);

  // every strobe traces back to a taken input beat
  `PDR_ASSERT_NOW(a_done_has_source, done, $past(start && !busy, PDR_LAT), "result without input beat")

  // every beat taken gives a strobe
  `PDR_ASSERT_NEXT(a_beat_gives_done, start && !busy, ##(PDR_LAT - 1) done, "input beat lost")

  // a floored result carries zero rate
  `PDR_ASSERT_NOW(a_floor_zero, done && clamp_kind == CLAMP_FLOOR, rate == '0, "floored rate not zero")

  // the clamp code is one of the three defined ones
  `PDR_ASSERT_NOW(a_clamp_code, done, clamp_kind == CLAMP_NONE || clamp_kind == CLAMP_CAP || clamp_kind == CLAMP_FLOOR, "bad clamp code")

endmodule

bind position_dependent_rate pdr_checker u_pdr_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .rate       (rate),
  .clamp_kind (clamp_kind)
);
